// ----- sv/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkvc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int CAP_W       = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [31:0]      READ_MISS = 32'hFFFF_FFFF;
	localparam logic [31:0]      READ_PUT  = 32'h0000_0000;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] lookup_key;
		logic signed [31:0] put_value;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} out_t;

endpackage
`default_nettype wire

// ----- sv/lkvc_store.sv -----
// Entry storage, parallel key match and recency rank update.
`default_nettype none
module lkvc_store #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	input  wire lkvc_pkg::in_t              req,
	input  wire logic [lkvc_pkg::CAP_W-1:0] capacity,
	output lkvc_pkg::out_t                  rsp
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	logic [31:0]       key_q  [ENTRIES];
	logic [31:0]       val_q  [ENTRIES];
	logic [RANK_W-1:0] rank_q [ENTRIES];
	logic [RANK_W-1:0] rank_d [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_d;
	logic [CNT_W-1:0]   occ_q;
	logic [CNT_W-1:0]   occ_d;

	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] lru_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] slot_vec;
	logic [ENTRIES-1:0] wr_vec;
	logic [CNT_W-1:0]   occ_m1;
	logic [RANK_W-1:0]  lru_rank;
	logic [RANK_W-1:0]  hit_rank;
	logic [31:0]        hit_data;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   eff_cap;
	logic               hit;
	logic               is_put;
	logic               full;
	logic               do_evict;
	logic               do_insert;

	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full     = CMP_W'(occ_q) >= eff_cap;
	assign occ_m1   = occ_q - CNT_W'(1);
	assign lru_rank = occ_m1[RANK_W-1:0];

	always_comb begin
		hit_rank = '0;
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == req.lookup_key);
			lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
			hit_rank   = hit_rank | (rank_q[i] & {RANK_W{hit_vec[i]}});
			hit_data   = hit_data | (val_q[i] & {32{hit_vec[i]}});
		end
	end

	// lowest clear bit of the valid mask
	assign free_vec = ~valid_q & (valid_q + ENTRIES'(1));

	assign hit       = |hit_vec;
	assign is_put    = (req.op == lkvc_pkg::OP_PUT);
	assign do_evict  = req_valid && is_put && !hit && full && (occ_q != '0);
	assign do_insert = req_valid && is_put && !hit;
	assign slot_vec  = do_evict ? lru_vec : free_vec;
	assign wr_vec    = do_insert ? slot_vec : (is_put && req_valid ? hit_vec : '0);

	always_comb begin
		valid_d = valid_q;
		occ_d   = occ_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (req_valid && hit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (hit_vec[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
		end else if (do_insert) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_vec[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
			valid_d = valid_q | slot_vec;
			if (!do_evict) begin
				occ_d = occ_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_vec[i]) begin
				val_q[i] <= req.put_value;
			end
			if (do_insert && slot_vec[i]) begin
				key_q[i] <= req.lookup_key;
			end
		end
	end

	always_comb begin
		rsp.hit     = hit;
		rsp.evicted = do_evict;
		if (is_put) begin
			rsp.read_value = lkvc_pkg::READ_PUT;
		end else if (hit) begin
			rsp.read_value = hit_data;
		end else begin
			rsp.read_value = lkvc_pkg::READ_MISS;
		end
	end

endmodule
`default_nettype wire

// ----- sv/lru_key_value_cache.sv -----
// Top level of the LRU key/value cache: command port, capacity register, result register.
// One get or put is taken on every cycle that start is high (busy stays low). The result
// beat appears on result with done two cycles after the start beat and cannot be stalled,
// so the receiver must take every beat. The key match over all entries and the recency
// rank update finish in the one cycle between the command register and the result
// register, which sets the rate of one item per clock.
`default_nettype none
module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire lkvc_pkg::in_t              item,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_data,
	output logic                            done,
	output lkvc_pkg::out_t                  result
);

	logic                       valid_s1;
	lkvc_pkg::in_t              item_s1;
	logic                       valid_s2;
	lkvc_pkg::out_t             result_s2;
	lkvc_pkg::out_t             rsp;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
		result_s2 <= rsp;
	end

	lkvc_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s1),
		.req       (item_s1),
		.capacity  (cap_q),
		.rsp       (rsp)
	);

	assign done   = valid_s2;
	assign result = result_s2;

	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result beat missing two cycles after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without a start beat");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.evicted |-> !result.hit && result.read_value == lkvc_pkg::READ_PUT)
		else $error("eviction reported on a hit or a get");

endmodule
`default_nettype wire

// ----- tb/lru_key_value_cache_tb.sv -----
// Self-checking testbench for the LRU key/value cache: directed and random gets and puts.
`default_nettype none
module lru_key_value_cache_tb;

	localparam int WATCHDOG = 5000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	lkvc_pkg::in_t              item = '0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;
	logic                       done;
	lkvc_pkg::out_t             result;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #1 clk = ~clk;

	// cache shadow
	logic signed [31:0]         slot_key [lkvc_pkg::ENTRIES_DEF];
	logic signed [31:0]         slot_val [lkvc_pkg::ENTRIES_DEF];
	bit                         slot_used [lkvc_pkg::ENTRIES_DEF];
	int                         slot_age [lkvc_pkg::ENTRIES_DEF];
	int                         occupancy = 0;
	logic [lkvc_pkg::CAP_W-1:0] capacity = lkvc_pkg::CAP_RESET;

	lkvc_pkg::in_t  cmd_q [$];
	lkvc_pkg::out_t want_q [$];
	logic signed [31:0] key_pool [$];

	int  mismatches = 0;
	int  quiet = 0;
	int  gap = 0;
	int  idle_odds = 0;
	bit  calm = 1'b0;

	initial begin
		for (int i = 0; i < lkvc_pkg::ENTRIES_DEF; i++) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_used[i] = 1'b0;
			slot_age[i] = 0;
		end
	end

	function automatic void make_recent(int e);
		for (int i = 0; i < lkvc_pkg::ENTRIES_DEF; i++)
			if (slot_used[i] && i != e && slot_age[i] < slot_age[e])
				slot_age[i]++;
		slot_age[e] = 0;
	endfunction

	function automatic lkvc_pkg::out_t cache_access(lkvc_pkg::in_t it);
		lkvc_pkg::out_t r;
		int   slot;
		int   oldest;
		int   cap;
		bit   found;
		r = '0;
		slot = 0;
		found = 1'b0;
		for (int i = 0; i < lkvc_pkg::ENTRIES_DEF; i++)
			if (!found && slot_used[i] && slot_key[i] == it.lookup_key) begin
				found = 1'b1;
				slot = i;
			end
		if (it.op == lkvc_pkg::OP_GET) begin
			if (found) begin
				r.hit = 1'b1;
				r.read_value = slot_val[slot];
				make_recent(slot);
			end else begin
				r.read_value = lkvc_pkg::READ_MISS;
			end
		end else if (found) begin
			r.hit = 1'b1;
			r.read_value = lkvc_pkg::READ_PUT;
			slot_val[slot] = it.put_value;
			make_recent(slot);
		end else begin
			r.read_value = lkvc_pkg::READ_PUT;
			cap = (capacity == 0) ? 1
				: (capacity > lkvc_pkg::ENTRIES_DEF) ? lkvc_pkg::ENTRIES_DEF
				: int'(capacity);
			if (occupancy >= cap) begin
				oldest = -1;
				for (int i = 0; i < lkvc_pkg::ENTRIES_DEF; i++)
					if (slot_used[i] && slot_age[i] > oldest) begin
						oldest = slot_age[i];
						slot = i;
					end
				if (oldest >= 0) begin
					slot_used[slot] = 1'b0;
					occupancy--;
					r.evicted = 1'b1;
				end
			end
			if (!r.evicted) begin
				for (int i = lkvc_pkg::ENTRIES_DEF - 1; i >= 0; i--)
					if (!slot_used[i])
						slot = i;
			end
			for (int i = 0; i < lkvc_pkg::ENTRIES_DEF; i++)
				if (slot_used[i])
					slot_age[i]++;
			slot_key[slot] = it.lookup_key;
			slot_val[slot] = it.put_value;
			slot_used[slot] = 1'b1;
			slot_age[slot] = 0;
			occupancy++;
		end
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap <= 0;
		end else begin
			if (start && !busy)
				want_q.push_back(cache_access(item));
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (cmd_q.size() != 0 && !calm && idle_odds != 0
					&& $urandom_range(0, 99) < idle_odds) begin
				gap <= $urandom_range(0, 12);
				start <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				start <= 1'b1;
				item <= cmd_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		lkvc_pkg::out_t w;
		if (arst_n) begin
			if (done) begin
				if (want_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: hit=%0b read_value=%h evicted=%0b",
							result.hit, result.read_value, result.evicted);
				end else begin
					w = want_q.pop_front();
					if (result.hit !== w.hit || result.read_value !== w.read_value
							|| result.evicted !== w.evicted) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: hit %0b/%0b read_value %h/%h ",
								"evicted %0b/%0b (exp/act)"},
								w.hit, result.hit, w.read_value, result.read_value,
								w.evicted, result.evicted);
					end
				end
			end
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else if (quiet >= WATCHDOG) begin
				$display("lru_key_value_cache_tb failed");
				$finish;
			end else begin
				quiet++;
			end
		end
	end

	task automatic queue_cmd(lkvc_pkg::op_t op, logic [31:0] key, logic [31:0] val);
		lkvc_pkg::in_t it;
		it.op = op;
		it.lookup_key = key;
		it.put_value = val;
		cmd_q.push_back(it);
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || start || want_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [lkvc_pkg::CAP_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		capacity = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		int eff;
		int pool_n;
		logic [31:0] key;
		eff = (capacity == 0) ? 1
			: (capacity > lkvc_pkg::ENTRIES_DEF) ? lkvc_pkg::ENTRIES_DEF
			: int'(capacity);
		pool_n = $urandom_range(eff, 2 * eff + 3);
		key_pool.delete();
		for (int i = 0; i < pool_n; i++) begin
			case ($urandom_range(0, 9))
				0: key_pool.push_back(32'h8000_0000);
				1: key_pool.push_back(32'h7FFF_FFFF);
				2: key_pool.push_back(32'hFFFF_FFFF);
				default: key_pool.push_back($urandom);
			endcase
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 12)
				key = $urandom;
			else
				key = key_pool[$urandom_range(0, pool_n - 1)];
			queue_cmd($urandom_range(0, 1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
				key, $urandom);
		end
	endtask

	initial begin
		logic [lkvc_pkg::CAP_W-1:0] caps [11];
		caps = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd3, 5'd8, 5'd2, 5'd12, 5'd5, 5'd16};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_odds = 15;
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1111_1111);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_cmd(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_cmd(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0);
		queue_cmd(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		queue_cmd(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(lkvc_pkg::OP_GET, 32'h1234_5678, 32'hFFFF_FFFF);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h55AA_55AA);
		queue_cmd(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);

		// shrink below occupancy, then evict
		set_capacity(5'd2);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0002, 32'h5555_5555);
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0003, 32'h0000_0003);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0011);
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0002, 32'h0);
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0003, 32'h0);
		queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0);
		queue_cmd(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0000);

		foreach (caps[p]) begin
			set_capacity(caps[p]);
			idle_odds = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
			calm = (p == 10);
			random_phase(175);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && want_q.size() == 0)
			$display("lru_key_value_cache_tb passed");
		else
			$display("lru_key_value_cache_tb failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- lru_key_value_cache.f -----
sv/lkvc_pkg.sv
sv/lkvc_store.sv
sv/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
